// File: rtl/q2e_pkg.sv
// ----------------------------------------------------------------------------
// q2e_pkg: shared constants for the quaternion to Euler angle unit
// Angle constants, CORDIC arctangent table and fixed pipeline sizes.
// ----------------------------------------------------------------------------
package q2e_pkg;

  // Width of the Q3.30 angle accumulator.
  localparam int ZW = 34;

  // pi/2 in Q3.30 and Q3.13, pi in Q3.13.
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam int HALF_PI_Q13 = 12868;
  localparam int PI_Q13 = 25736;

  // The square root works on a 61-bit remainder, one result bit per cell.
  localparam int RW = 61;
  localparam int ISQRT_STEPS = 31;

  // atan(2^-i) in Q3.30.
  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] a;
    case (i)
      0: a = 34'sd843314856;
      1: a = 34'sd497837829;
      2: a = 34'sd263043836;
      3: a = 34'sd133525158;
      4: a = 34'sd67021686;
      5: a = 34'sd33543515;
      6: a = 34'sd16775850;
      7: a = 34'sd8388437;
      8: a = 34'sd4194282;
      9: a = 34'sd2097149;
      10: a = 34'sd1048575;
      11: a = 34'sd524287;
      12: a = 34'sd262143;
      13: a = 34'sd131071;
      14: a = 34'sd65535;
      15: a = 34'sd32767;
      16: a = 34'sd16383;
      17: a = 34'sd8191;
      18: a = 34'sd4095;
      19: a = 34'sd2047;
      20: a = 34'sd1023;
      21: a = 34'sd511;
      22: a = 34'sd255;
      23: a = 34'sd127;
      24: a = 34'sd63;
      25: a = 34'sd31;
      26: a = 34'sd15;
      27: a = 34'sd7;
      28: a = 34'sd3;
      29: a = 34'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/quaternion_to_euler_angles_unit.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_unit: unit quaternion to Z-Y-X Euler angles
// Roll and yaw by pipelined atan2, pitch by square root and atan2.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one quaternion word (w, x, y, z, each signed
//   Q1.14 at the default sample width). The master stream gives one word
//   of roll and yaw in signed Q3.13 and pitch in signed Q1.13 radians;
//   tuser flags a pitch that was clamped to plus or minus pi/2.
//   The datapath is a fixed pipeline: two product and sum stages, the
//   squaring and remainder registers, the 31-cell square root, and
//   CORDIC_STAGES + 2 CORDIC stages, then the output register. One word
//   is taken every cycle while s_tready is high.
//   When the receiver stalls, the pipeline keeps running until a word
//   arrives that cannot leave; it then sits in a one-word skid register
//   and s_tready drops until the receiver takes the output word again.
//   Reset clears all valid flags; words in flight are dropped.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_unit #(
  parameter int SAMPLE_WIDTH  = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // quat_w, quat_x, quat_y, quat_z from the lowest bits up
  input  logic [((4*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // roll_angle [15:0], pitch_angle [30:16], yaw_angle [46:31], zero pad [47]
  output logic [47:0] m_tdata,
  // pitch_saturated
  output logic m_tuser
);
  import q2e_pkg::*;

  localparam int E      = (SAMPLE_WIDTH > 24) ? 24 : SAMPLE_WIDTH;
  localparam int IN_SH  = SAMPLE_WIDTH - E;
  localparam int FB     = E - 2;
  localparam int PW     = 2 * E;
  localparam int SUMW   = 2 * E + 3;
  localparam int CDW    = SUMW + 1;
  localparam int SH_R   = (2 * FB >= 30) ? 2 * FB - 30 : 0;
  localparam int SH_L   = (2 * FB >= 30) ? 0 : 30 - 2 * FB;
  localparam int EXW    = SUMW + SH_L;
  localparam int SQ_DLY = ISQRT_STEPS + 2;
  localparam int LAT    = SQ_DLY + CORDIC_STAGES + 2;

  localparam logic signed [SUMW-1:0] ONE = SUMW'(1) <<< (2 * FB);
  localparam logic [RW-1:0] FULL = RW'(1) << 60;
  localparam logic signed [14:0] PITCH_MAX = 15'(HALF_PI_Q13);

  logic en;

  // Samples with the low bits beyond 24 dropped.
  logic signed [E-1:0] qw, qx, qy, qz;

  logic signed [PW-1:0] p_wx, p_yz, p_xx, p_yy, p_wy, p_zx, p_wz, p_xy, p_zz;
  logic                 v_p;

  logic signed [SUMW-1:0] sinr, cosr, sinp, siny, cosy;
  logic signed [SUMW-1:0] sinr_q, cosr_q, siny_q, cosy_q;
  logic signed [EXW-1:0]  sp_ext;
  logic signed [30:0]     s30_c, s30_q;
  logic                   sat_q, pos_q, v_q;

  logic [61:0]   sq_r;
  logic [RW-1:0] rem_t;
  logic [RW-1:0] n_a [ISQRT_STEPS+1];
  logic [RW-1:0] r_a [ISQRT_STEPS+1];
  logic [30:0]   s30_d;
  logic [1:0]    satpos_d;

  logic signed [15:0] roll_c, yaw_c, roll_d, yaw_d;
  logic signed [14:0] pitch_c, pitch_f;

  logic [LAT-1:0] vchain;
  logic           pipe_valid;
  logic [46:0]    pipe_word;
  logic           pipe_sat;
  logic [46:0]    skid_word;
  logic           skid_sat;
  logic           skid_valid;

  assign en       = !skid_valid;
  assign s_tready = en;

  assign qw = $signed(s_tdata[0*SAMPLE_WIDTH+IN_SH +: E]);
  assign qx = $signed(s_tdata[1*SAMPLE_WIDTH+IN_SH +: E]);
  assign qy = $signed(s_tdata[2*SAMPLE_WIDTH+IN_SH +: E]);
  assign qz = $signed(s_tdata[3*SAMPLE_WIDTH+IN_SH +: E]);

  always_ff @(posedge clk) begin
    if (en) begin
      p_wx <= qw * qx;
      p_yz <= qy * qz;
      p_xx <= qx * qx;
      p_yy <= qy * qy;
      p_wy <= qw * qy;
      p_zx <= qz * qx;
      p_wz <= qw * qz;
      p_xy <= qx * qy;
      p_zz <= qz * qz;
    end
  end

  always_comb begin
    sinr   = (SUMW'(p_wx) + SUMW'(p_yz)) <<< 1;
    cosr   = ONE - ((SUMW'(p_xx) + SUMW'(p_yy)) <<< 1);
    sinp   = (SUMW'(p_wy) - SUMW'(p_zx)) <<< 1;
    siny   = (SUMW'(p_wz) + SUMW'(p_xy)) <<< 1;
    cosy   = ONE - ((SUMW'(p_yy) + SUMW'(p_zz)) <<< 1);
    sp_ext = (EXW'(sinp) <<< SH_L) >>> SH_R;
    s30_c  = sp_ext[30:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sinr_q <= sinr;
      cosr_q <= cosr;
      siny_q <= siny;
      cosy_q <= cosy;
      s30_q  <= s30_c;
      sat_q  <= (sinp >= ONE) || (sinp <= -ONE);
      pos_q  <= sinp > 0;
    end
  end

  // Cosine of pitch: sqrt(1 - s^2) with s in Q0.30.
  always_ff @(posedge clk) begin
    if (en) begin
      sq_r  <= 62'(s30_q * s30_q);
      rem_t <= FULL - sq_r[RW-1:0];
    end
  end

  assign n_a[0] = rem_t;
  assign r_a[0] = '0;

  for (genvar k = 0; k < ISQRT_STEPS; k++) begin : g_sqrt
    q2e_isqrt_cell #(
      .BPOS(60 - 2 * k)
    ) u_sqrt (
      .clk  (clk),
      .en   (en),
      .n_in (n_a[k]),
      .r_in (r_a[k]),
      .n_out(n_a[k+1]),
      .r_out(r_a[k+1])
    );
  end

  q2e_delay #(
    .WIDTH(31),
    .DEPTH(SQ_DLY)
  ) u_s30_dly (
    .clk (clk),
    .en  (en),
    .din (s30_q),
    .dout(s30_d)
  );

  q2e_delay #(
    .WIDTH(2),
    .DEPTH(LAT)
  ) u_sat_dly (
    .clk (clk),
    .en  (en),
    .din ({sat_q, pos_q}),
    .dout(satpos_d)
  );

  q2e_cordic #(
    .DW    (CDW),
    .STAGES(CORDIC_STAGES),
    .LIMIT (PI_Q13),
    .OW    (16)
  ) u_roll (
    .clk  (clk),
    .en   (en),
    .y_in (CDW'(sinr_q)),
    .x_in (CDW'(cosr_q)),
    .angle(roll_c)
  );

  q2e_cordic #(
    .DW    (CDW),
    .STAGES(CORDIC_STAGES),
    .LIMIT (PI_Q13),
    .OW    (16)
  ) u_yaw (
    .clk  (clk),
    .en   (en),
    .y_in (CDW'(siny_q)),
    .x_in (CDW'(cosy_q)),
    .angle(yaw_c)
  );

  q2e_cordic #(
    .DW    (ZW),
    .STAGES(CORDIC_STAGES),
    .LIMIT (HALF_PI_Q13),
    .OW    (15)
  ) u_pitch (
    .clk  (clk),
    .en   (en),
    .y_in (ZW'($signed(s30_d))),
    .x_in ($signed({3'b000, r_a[ISQRT_STEPS][30:0]})),
    .angle(pitch_c)
  );

  q2e_delay #(
    .WIDTH(32),
    .DEPTH(SQ_DLY)
  ) u_ry_dly (
    .clk (clk),
    .en  (en),
    .din ({roll_c, yaw_c}),
    .dout({roll_d, yaw_d})
  );

  always_comb begin
    if (satpos_d[1]) begin
      pitch_f = satpos_d[0] ? PITCH_MAX : -PITCH_MAX;
    end else begin
      pitch_f = pitch_c;
    end
    pipe_word = {yaw_d, pitch_f, roll_d};
    pipe_sat  = satpos_d[1];
    pipe_valid = vchain[LAT-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_p    <= 1'b0;
      v_q    <= 1'b0;
      vchain <= '0;
    end else if (en) begin
      v_p    <= s_tvalid;
      v_q    <= v_p;
      vchain <= {vchain[LAT-2:0], v_q};
    end
  end

  // Output register with a one-word skid behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tvalid && !m_tready) begin
      if (en && pipe_valid) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      m_tvalid   <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      m_tvalid <= en && pipe_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tvalid && !m_tready) begin
      if (en && pipe_valid) begin
        skid_word <= pipe_word;
        skid_sat  <= pipe_sat;
      end
    end else if (skid_valid) begin
      m_tdata <= {1'b0, skid_word};
      m_tuser <= skid_sat;
    end else if (en && pipe_valid) begin
      m_tdata <= {1'b0, pipe_word};
      m_tuser <= pipe_sat;
    end
  end

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid word held while output register empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(m_tvalid && !m_tready))
    else $error("skid filled while output was free");

  a_sat_pitch: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |->
      (m_tdata[30:16] == 15'd12868 || m_tdata[30:16] == 15'h4DBC))
    else $error("saturated pitch is not plus or minus pi/2");
`endif

endmodule

// File: rtl/q2e_delay.sv
// ----------------------------------------------------------------------------
// q2e_delay: enabled delay line
// Carries side data alongside the arithmetic pipeline, one register per stage.
// ----------------------------------------------------------------------------
module q2e_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= din;
      for (int k = 1; k < DEPTH; k++) begin
        taps[k] <= taps[k-1];
      end
    end
  end

  assign dout = taps[DEPTH-1];

endmodule

// File: rtl/q2e_isqrt_cell.sv
// ----------------------------------------------------------------------------
// q2e_isqrt_cell: one digit of the integer square root
// Tries one result bit against the remainder and passes both on.
// ----------------------------------------------------------------------------
module q2e_isqrt_cell #(
  parameter int BPOS = 60
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [q2e_pkg::RW-1:0] n_in,
  input  logic [q2e_pkg::RW-1:0] r_in,
  output logic [q2e_pkg::RW-1:0] n_out,
  output logic [q2e_pkg::RW-1:0] r_out
);
  import q2e_pkg::*;

  localparam logic [RW-1:0] BIT = RW'(1) << BPOS;

  logic [RW-1:0] trial;

  assign trial = r_in + BIT;

  always_ff @(posedge clk) begin
    if (en) begin
      if (n_in >= trial) begin
        n_out <= n_in - trial;
        r_out <= (r_in >> 1) + BIT;
      end else begin
        n_out <= n_in;
        r_out <= r_in >> 1;
      end
    end
  end

endmodule

// File: rtl/q2e_cordic_cell.sv
// ----------------------------------------------------------------------------
// q2e_cordic_cell: one vectoring CORDIC micro-rotation
// Rotates the vector toward the x axis and accumulates the angle.
// ----------------------------------------------------------------------------
module q2e_cordic_cell #(
  parameter int DW    = 36,
  parameter int SHIFT = 0
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [DW-1:0]          x_in,
  input  logic signed [DW-1:0]          y_in,
  input  logic signed [q2e_pkg::ZW-1:0] z_in,
  input  logic                          zero_in,
  output logic signed [DW-1:0]          x_out,
  output logic signed [DW-1:0]          y_out,
  output logic signed [q2e_pkg::ZW-1:0] z_out,
  output logic                          zero_out
);
  import q2e_pkg::*;

  localparam logic signed [ZW-1:0] ANGLE = atan_q30(SHIFT);

  logic signed [DW-1:0] xs;
  logic signed [DW-1:0] ys;

  assign xs = x_in >>> SHIFT;
  assign ys = y_in >>> SHIFT;

  always_ff @(posedge clk) begin
    if (en) begin
      zero_out <= zero_in;
      if (y_in > 0) begin
        x_out <= x_in + ys;
        y_out <= y_in - xs;
        z_out <= z_in + ANGLE;
      end else begin
        x_out <= x_in - ys;
        y_out <= y_in + xs;
        z_out <= z_in - ANGLE;
      end
    end
  end

endmodule

// File: rtl/q2e_cordic.sv
// ----------------------------------------------------------------------------
// q2e_cordic: pipelined atan2
// Quadrant fold, a row of micro-rotation cells, then rounding to Q3.13 and a clamp.
// ----------------------------------------------------------------------------
module q2e_cordic #(
  parameter int DW     = 36,
  parameter int STAGES = 16,
  parameter int LIMIT  = 25736,
  parameter int OW     = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [DW-1:0] y_in,
  input  logic signed [DW-1:0] x_in,
  output logic signed [OW-1:0] angle
);
  import q2e_pkg::*;

  localparam logic signed [16:0] LIM = 17'(LIMIT);
  localparam logic signed [ZW-1:0] HALF_LSB = ZW'(1) <<< 16;

  logic signed [DW-1:0] xa [STAGES+1];
  logic signed [DW-1:0] ya [STAGES+1];
  logic signed [ZW-1:0] za [STAGES+1];
  logic                 zf [STAGES+1];

  logic signed [DW-1:0] x_pre;
  logic signed [DW-1:0] y_pre;
  logic signed [ZW-1:0] z_pre;
  logic signed [ZW-1:0] z_rnd;
  logic signed [16:0]   z_q13;
  logic signed [16:0]   z_clip;

  // Left half-plane vectors are turned by a quarter turn first.
  always_comb begin
    x_pre = x_in;
    y_pre = y_in;
    z_pre = '0;
    if (x_in < 0) begin
      if (y_in >= 0) begin
        x_pre = y_in;
        y_pre = -x_in;
        z_pre = HALF_PI_Q30;
      end else begin
        x_pre = -y_in;
        y_pre = x_in;
        z_pre = -HALF_PI_Q30;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xa[0] <= x_pre;
      ya[0] <= y_pre;
      za[0] <= z_pre;
      zf[0] <= (x_in == 0) && (y_in == 0);
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    q2e_cordic_cell #(
      .DW   (DW),
      .SHIFT(i)
    ) u_cell (
      .clk     (clk),
      .en      (en),
      .x_in    (xa[i]),
      .y_in    (ya[i]),
      .z_in    (za[i]),
      .zero_in (zf[i]),
      .x_out   (xa[i+1]),
      .y_out   (ya[i+1]),
      .z_out   (za[i+1]),
      .zero_out(zf[i+1])
    );
  end

  // Round half up to Q3.13, then clamp.
  always_comb begin
    z_rnd = za[STAGES] + HALF_LSB;
    z_q13 = z_rnd[ZW-1:17];
    if (z_q13 > LIM) begin
      z_clip = LIM;
    end else if (z_q13 < -LIM) begin
      z_clip = -LIM;
    end else begin
      z_clip = z_q13;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= zf[STAGES] ? '0 : OW'(z_clip);
    end
  end

endmodule
